// ===== hw/rtl/kinetic_scroll_integrator_top_assert.svh =====
// Assertion macros for the kinetic scroll integrator.
`ifndef KINETIC_SCROLL_INTEGRATOR_TOP_ASSERT_SVH
`define KINETIC_SCROLL_INTEGRATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define KSI_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");
`define KSI_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define KSI_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define KSI_ASSERT_ALWAYS(label, clk, rst, cond)
`define KSI_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define KSI_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hw/rtl/ksi_pkg.sv =====
// Package with constants, decay table and microprogram of the kinetic scroll integrator.
package ksi_pkg;

  localparam int DECAY_ENTRIES = 51;
  localparam int DECAY_IDX_W = $clog2(DECAY_ENTRIES);

  localparam logic [7:0] MAX_DT_MS = 8'd50;
  localparam logic signed [22:0] VEL_LIMIT = 23'sd3072000;
  localparam logic signed [23:0] TV_LIMIT = 24'sd3072000;
  localparam logic signed [23:0] FLING_Q8 = 24'sd30720;
  localparam logic [21:0] SETTLE_Q8 = 22'd2048;
  localparam logic [21:0] PREFETCH_Q8 = 22'd102400;
  localparam int COUNT_STEP_Q8 = 307200;
  localparam int COUNT_STEPS = 6;
  localparam logic [23:0] CONTENT_DEFAULT = 24'd10000000;
  localparam logic [31:0] MAX_SCROLL_RESET = {CONTENT_DEFAULT, 8'd0};
  localparam logic [37:0] ROUND_BIAS = 38'd16384;
  localparam logic [27:0] DIV_BIAS = 28'd500;
  localparam logic [28:0] RECIP_1000 = 29'd274877907;

  typedef enum logic [2:0] {
    MODE_TICK,
    MODE_DRAG_START,
    MODE_DRAG_MOVE,
    MODE_DRAG_END,
    MODE_SET_OFFSET
  } mode_t;

  localparam logic REG_VIEWPORT = 1'b0;
  localparam logic REG_CONTENT = 1'b1;

  localparam logic [15:0] DECAY_ROM [DECAY_ENTRIES] = '{
    16'd32768, 16'd32572, 16'd32377, 16'd32183, 16'd31991, 16'd31800, 16'd31609,
    16'd31420, 16'd31232, 16'd31045, 16'd30860, 16'd30675, 16'd30492, 16'd30309,
    16'd30128, 16'd29948, 16'd29769, 16'd29590, 16'd29413, 16'd29238, 16'd29063,
    16'd28889, 16'd28716, 16'd28544, 16'd28373, 16'd28204, 16'd28035, 16'd27867,
    16'd27701, 16'd27535, 16'd27370, 16'd27206, 16'd27044, 16'd26882, 16'd26721,
    16'd26561, 16'd26402, 16'd26244, 16'd26087, 16'd25931, 16'd25776, 16'd25622,
    16'd25469, 16'd25316, 16'd25165, 16'd25014, 16'd24865, 16'd24716, 16'd24568,
    16'd24421, 16'd24275
  };

  typedef logic [3:0] step_t;

  localparam step_t STEP_FETCH = 4'd0;
  localparam step_t STEP_EVENT = 4'd1;
  localparam step_t STEP_MUL_DECAY = 4'd2;
  localparam step_t STEP_ROUND = 4'd3;
  localparam step_t STEP_MUL_DT = 4'd4;
  localparam step_t STEP_BIAS = 4'd5;
  localparam step_t STEP_MUL_RECIP = 4'd6;
  localparam step_t STEP_MOVE = 4'd7;
  localparam step_t STEP_EMIT = 4'd8;

  typedef enum logic [2:0] {
    JC_NEXT,
    JC_JUMP,
    JC_WAIT_IN,
    JC_SKIP,
    JC_WAIT_OUT
  } jcond_t;

  typedef enum logic [1:0] {
    OPA_HOLD,
    OPA_MAG,
    OPA_ROUND,
    OPA_BIAS
  } opa_src_t;

  typedef enum logic [1:0] {
    MB_NONE,
    MB_ROM,
    MB_MS,
    MB_RECIP
  } mulb_t;

  typedef struct packed {
    jcond_t jcond;
    step_t target;
    opa_src_t opa_src;
    mulb_t mul_b;
    logic take;
    logic do_event;
    logic vel_round;
    logic do_move;
    logic emit;
  } uword_t;

  function automatic uword_t ucode(input step_t s);
    uword_t w;
    w = '{jcond: JC_NEXT, target: STEP_FETCH, opa_src: OPA_HOLD, mul_b: MB_NONE,
          take: 1'b0, do_event: 1'b0, vel_round: 1'b0, do_move: 1'b0, emit: 1'b0};
    case (s)
      STEP_FETCH: begin
        w.jcond = JC_WAIT_IN;
        w.take = 1'b1;
      end
      STEP_EVENT: begin
        w.jcond = JC_SKIP;
        w.target = STEP_EMIT;
        w.do_event = 1'b1;
        w.opa_src = OPA_MAG;
      end
      STEP_MUL_DECAY: w.mul_b = MB_ROM;
      STEP_ROUND: begin
        w.opa_src = OPA_ROUND;
        w.vel_round = 1'b1;
      end
      STEP_MUL_DT: w.mul_b = MB_MS;
      STEP_BIAS: w.opa_src = OPA_BIAS;
      STEP_MUL_RECIP: w.mul_b = MB_RECIP;
      STEP_MOVE: w.do_move = 1'b1;
      STEP_EMIT: begin
        w.jcond = JC_WAIT_OUT;
        w.target = STEP_FETCH;
        w.emit = 1'b1;
      end
      default: begin
        w.jcond = JC_JUMP;
        w.target = STEP_FETCH;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/kinetic_scroll_integrator_top.sv =====
// Kinetic scroll integrator: microcoded sequencer with one shared multiplier.
// A drag event, set offset, unused mode or a tick that settles goes from the fetch step
// through the event step straight to the emit step; a moving tick goes through the
// nine-step microprogram, which runs the decay, the step and the divide by 1000 as
// three passes through the shared 28 by 29 bit multiplier. The result goes to an output
// register, so the next transaction is accepted while the previous result still waits.
`include "kinetic_scroll_integrator_top_assert.svh"

module kinetic_scroll_integrator_top
  import ksi_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         mode,
  input  logic [7:0]         elapsed_ms,
  input  logic signed [24:0] drag_delta,
  input  logic signed [23:0] touch_velocity,
  input  logic [31:0]        new_offset,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        scroll_pos,
  output logic signed [22:0] scroll_vel,
  output logic signed [18:0] step_move,
  output logic               is_settled,
  output logic               want_prefetch,
  output logic [3:0]         prefetch_count,
  output logic signed [1:0]  prefetch_dir
);

  logic [23:0] viewport;
  logic [23:0] content;
  logic [31:0] max_scroll;
  logic [31:0] max_scroll_next;
  logic [23:0] content_eff;

  step_t pc;
  step_t pc_next;
  uword_t uw;

  logic in_fire;
  logic out_free;

  logic [2:0] mode_q;
  logic [5:0] ms_q;
  logic signed [24:0] delta_q;
  logic signed [23:0] tv_q;
  logic [31:0] off_q;

  logic [31:0] position;
  logic [31:0] position_next;
  logic signed [22:0] velocity;
  logic signed [22:0] velocity_next;
  logic dragging;
  logic dragging_next;
  logic signed [18:0] step;
  logic signed [18:0] step_next;
  logic neg;
  logic neg_next;

  logic [27:0] opa;
  logic [27:0] opa_next;
  logic [56:0] prod;
  logic [28:0] mul_b;

  logic [21:0] vel_mag;
  logic tick_moving;
  logic signed [22:0] tv_clamped;
  logic signed [33:0] drag_sum;
  logic [37:0] round_sum;
  logic [21:0] rounded;
  logic signed [22:0] rounded_s;
  logic [18:0] travel;
  logic signed [33:0] move_sum;

  logic [2:0] count_k;
  logic [3:0] count_next;

  assign pready = 1'b1;

  always_comb begin
    content_eff = (content == 24'd0) ? CONTENT_DEFAULT : content;
    if (content_eff > viewport) begin
      max_scroll_next = {content_eff - viewport, 8'd0};
    end else begin
      max_scroll_next = 32'd0;
    end
  end

  always_comb begin
    case (paddr[2])
      REG_VIEWPORT: prdata = {8'd0, viewport};
      REG_CONTENT: prdata = {8'd0, content};
      default: prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      viewport <= 24'd0;
      content <= CONTENT_DEFAULT;
      max_scroll <= MAX_SCROLL_RESET;
    end else begin
      max_scroll <= max_scroll_next;
      if (psel && penable && pwrite && pready) begin
        case (paddr[2])
          REG_VIEWPORT: viewport <= pwdata[23:0];
          REG_CONTENT: content <= pwdata[23:0];
          default: ;
        endcase
      end
    end
  end

  assign uw = ucode(pc);
  assign in_ready = uw.take && !rst;
  assign in_fire = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  assign vel_mag = velocity[22] ? 22'(-velocity) : velocity[21:0];
  assign tick_moving = (mode_q == MODE_TICK) && !dragging && (vel_mag > SETTLE_Q8);

  always_comb begin
    case (uw.jcond)
      JC_NEXT: pc_next = pc + 4'd1;
      JC_JUMP: pc_next = uw.target;
      JC_WAIT_IN: pc_next = in_fire ? pc + 4'd1 : pc;
      JC_SKIP: pc_next = tick_moving ? pc + 4'd1 : uw.target;
      JC_WAIT_OUT: pc_next = out_free ? uw.target : pc;
      default: pc_next = STEP_FETCH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_FETCH;
    end else begin
      pc <= pc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_q <= mode;
      ms_q <= (elapsed_ms > MAX_DT_MS) ? MAX_DT_MS[5:0] : elapsed_ms[5:0];
      delta_q <= drag_delta;
      tv_q <= touch_velocity;
      off_q <= new_offset;
    end
  end

  always_comb begin
    case (uw.mul_b)
      MB_ROM: mul_b = 29'(DECAY_ROM[ms_q[DECAY_IDX_W-1:0]]);
      MB_MS: mul_b = 29'(ms_q);
      MB_RECIP: mul_b = RECIP_1000;
      default: mul_b = 29'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (uw.mul_b != MB_NONE) begin
      prod <= 57'(opa) * 57'(mul_b);
    end
  end

  assign round_sum = prod[37:0] + ROUND_BIAS;
  assign rounded = round_sum[36:15];
  assign rounded_s = signed'({1'b0, rounded});

  always_comb begin
    case (uw.opa_src)
      OPA_MAG: opa_next = 28'(vel_mag);
      OPA_ROUND: opa_next = 28'(rounded);
      OPA_BIAS: opa_next = prod[27:0] + DIV_BIAS;
      default: opa_next = opa;
    endcase
  end

  always_ff @(posedge clk) begin
    opa <= opa_next;
  end

  always_comb begin
    if (tv_q > TV_LIMIT) begin
      tv_clamped = VEL_LIMIT;
    end else if (tv_q < -TV_LIMIT) begin
      tv_clamped = -VEL_LIMIT;
    end else begin
      tv_clamped = tv_q[22:0];
    end
  end

  assign drag_sum = signed'({2'b00, position}) + 34'(delta_q);
  assign travel = prod[56:38];
  assign move_sum = neg ? signed'({2'b00, position}) - signed'({15'd0, travel})
                        : signed'({2'b00, position}) + signed'({15'd0, travel});

  always_comb begin
    position_next = position;
    velocity_next = velocity;
    dragging_next = dragging;
    step_next = step;
    neg_next = neg;
    if (uw.do_event) begin
      step_next = 19'sd0;
      neg_next = velocity[22];
      case (mode_q)
        MODE_TICK: begin
          if (!tick_moving) begin
            velocity_next = 23'sd0;
          end
        end
        MODE_DRAG_START: begin
          dragging_next = 1'b1;
          velocity_next = 23'sd0;
        end
        MODE_DRAG_MOVE: begin
          velocity_next = tv_clamped;
          if (drag_sum < 34'sd0) begin
            position_next = 32'd0;
          end else if (drag_sum > signed'({2'b00, max_scroll})) begin
            position_next = max_scroll;
          end else begin
            position_next = drag_sum[31:0];
          end
        end
        MODE_DRAG_END: begin
          dragging_next = 1'b0;
          if (tv_q >= FLING_Q8 || tv_q <= -FLING_Q8) begin
            velocity_next = tv_clamped;
          end else begin
            velocity_next = 23'sd0;
          end
        end
        MODE_SET_OFFSET: begin
          position_next = (off_q > max_scroll) ? max_scroll : off_q;
        end
        default: ;
      endcase
    end
    if (uw.vel_round) begin
      velocity_next = neg ? -rounded_s : rounded_s;
    end
    if (uw.do_move) begin
      if (move_sum < 34'sd0) begin
        position_next = 32'd0;
        velocity_next = 23'sd0;
      end else if (move_sum > signed'({2'b00, max_scroll})) begin
        position_next = max_scroll;
        velocity_next = 23'sd0;
      end else begin
        position_next = move_sum[31:0];
      end
      step_next = 19'(position_next - position);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= 32'd0;
      velocity <= 23'sd0;
      dragging <= 1'b0;
    end else begin
      position <= position_next;
      velocity <= velocity_next;
      dragging <= dragging_next;
    end
  end

  always_ff @(posedge clk) begin
    step <= step_next;
    neg <= neg_next;
  end

  always_comb begin
    count_k = 3'd0;
    for (int j = 1; j <= COUNT_STEPS; j++) begin
      if (vel_mag >= 22'(j * COUNT_STEP_Q8)) begin
        count_k = count_k + 3'd1;
      end
    end
    count_next = 4'd2 + 4'(count_k);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (uw.emit && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uw.emit && out_free) begin
      scroll_pos <= position;
      scroll_vel <= velocity;
      step_move <= step;
      is_settled <= !dragging && (vel_mag <= SETTLE_Q8);
      want_prefetch <= !dragging && (vel_mag >= PREFETCH_Q8);
      if (vel_mag >= PREFETCH_Q8) begin
        prefetch_count <= count_next;
        prefetch_dir <= velocity[22] ? -2'sd1 : 2'sd1;
      end else begin
        prefetch_count <= 4'd0;
        prefetch_dir <= 2'sd0;
      end
    end
  end

  `KSI_ASSERT_ALWAYS(a_vel_bound, clk, rst, velocity >= -VEL_LIMIT && velocity <= VEL_LIMIT)
  `KSI_ASSERT_NEXT(a_move_in_range, clk, rst, uw.do_move, position <= max_scroll)
  `KSI_ASSERT_IMPLY(a_move_not_dragging, clk, rst, uw.do_move, !dragging)
  `KSI_ASSERT_NEXT(a_accept_starts_event, clk, rst, in_fire, pc == STEP_EVENT)

endmodule
